@@ design/mtep_pkg.sv @@
// Package for the MIDI track event parser: parse phases, event and error
// codes, byte constants and the meta length limit.
// No dependencies.
package mtep_pkg;

    localparam int MAX_META_LEN = 999;
    localparam int META_CNT_W   = $clog2(MAX_META_LEN + 1);

    typedef enum logic [2:0] {
        PH_HALT,
        PH_DELTA,
        PH_STATUS,
        PH_META_TYPE,
        PH_META_LEN,
        PH_META_DATA,
        PH_CH_D1,
        PH_CH_D2
    } phase_t;

    typedef enum logic [2:0] {
        EV_NOTE_OFF   = 3'd0,
        EV_NOTE_ON    = 3'd1,
        EV_TEMPO      = 3'd2,
        EV_TRACK_NAME = 3'd3,
        EV_END_TRACK  = 3'd4,
        EV_ERROR      = 3'd5
    } event_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_BAD_STATUS  = 3'd1,
        ERR_CH_TYPE     = 3'd2,
        ERR_META_TYPE   = 3'd3,
        ERR_META_LONG   = 3'd4,
        ERR_TEMPO_LEN   = 3'd5
    } error_code_t;

    localparam logic [7:0] META_PREFIX   = 8'hFF;
    localparam logic [7:0] STATUS_CH_MAX = 8'hEF;
    localparam logic [7:0] STATUS_SYS    = 8'hF0;

    localparam logic [7:0] META_TRACK_NAME = 8'h03;
    localparam logic [7:0] META_MARKER     = 8'h06;
    localparam logic [7:0] META_END_TRACK  = 8'h2F;
    localparam logic [7:0] META_SET_TEMPO  = 8'h51;
    localparam logic [7:0] META_TIME_SIG   = 8'h58;

    localparam logic [3:0] CH_NOTE_OFF = 4'h8;
    localparam logic [3:0] CH_NOTE_ON  = 4'h9;
    localparam logic [3:0] CH_CTRL     = 4'hB;
    localparam logic [3:0] CH_PROGRAM  = 4'hC;
    localparam logic [3:0] CH_BEND     = 4'hE;

    function automatic logic ch_type_handled(input logic [3:0] t);
        return (t == CH_NOTE_OFF) || (t == CH_NOTE_ON) || (t == CH_CTRL) ||
               (t == CH_PROGRAM) || (t == CH_BEND);
    endfunction

endpackage

@@ design/mtep_if.sv @@
// Valid/ready channel interfaces of the MIDI track event parser:
// track byte channel and event channel. No dependencies.
interface mtep_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_track;
    logic [7:0] track_id;

    modport source (output valid, data_byte, new_track, track_id, input ready);
    modport sink   (input valid, data_byte, new_track, track_id, output ready);
endinterface

interface mtep_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [2:0]  error_code;
    logic [31:0] tick_time;
    logic [7:0]  track_number;
    logic [3:0]  channel;
    logic [7:0]  note_key;
    logic [7:0]  velocity;
    logic [23:0] tempo_us;

    modport source (output valid, event_kind, error_code, tick_time, track_number,
                    channel, note_key, velocity, tempo_us, input ready);
    modport sink   (input valid, event_kind, error_code, tick_time, track_number,
                    channel, note_key, velocity, tempo_us, output ready);
endinterface

@@ design/midi_track_event_parser_top.sv @@
// MIDI track event parser: one track byte per transfer, zero or one event out.
// Throughput: 1 byte per cycle, set by the combinational parse state update
// between the input and result registers, which hold the byte and the event;
// stalls only while an event waits at the output.
// Reset (rst_n, async, active low): parser halted until a byte with new_track.
// Depends on mtep_pkg and mtep_if.
module midi_track_event_parser_top
    import mtep_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mtep_byte_if.sink    track_bytes,
    mtep_event_if.source events
);

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_new_reg;
    logic [7:0] in_id_reg;

    // parse state
    phase_t                phase_reg, phase_next;
    logic [31:0]           vlq_reg, vlq_next;
    logic [31:0]           tick_reg, tick_next;
    logic [7:0]            rs_reg, rs_next;
    logic [7:0]            track_reg, track_next;
    logic [7:0]            mkind_reg, mkind_next;
    logic [31:0]           mrem_reg, mrem_next;
    logic [META_CNT_W-1:0] mcnt_reg, mcnt_next;
    logic [23:0]           tempo_reg, tempo_next;
    logic [7:0]            fdb_reg, fdb_next;

    // result stage
    logic        out_valid_reg;
    event_kind_t out_kind_reg, res_kind;
    error_code_t out_code_reg, res_code;
    logic [31:0] out_tick_reg;
    logic [7:0]  out_track_reg;
    logic [3:0]  out_ch_reg, res_ch;
    logic [7:0]  out_key_reg, res_key;
    logic [7:0]  out_vel_reg, res_vel;
    logic [23:0] out_tempo_reg, res_tempo;
    logic        res_valid;

    logic advance;
    logic proc;
    logic finish;
    logic [7:0] b;

    assign advance = !out_valid_reg || events.ready;
    assign proc    = in_valid_reg && advance;
    assign track_bytes.ready = !in_valid_reg || advance;
    assign b = in_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (track_bytes.ready)
        begin
            in_valid_reg <= track_bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (track_bytes.ready && track_bytes.valid)
        begin
            in_byte_reg <= track_bytes.data_byte;
            in_new_reg  <= track_bytes.new_track;
            in_id_reg   <= track_bytes.track_id;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        vlq_next   = vlq_reg;
        tick_next  = tick_reg;
        rs_next    = rs_reg;
        track_next = track_reg;
        mkind_next = mkind_reg;
        mrem_next  = mrem_reg;
        mcnt_next  = mcnt_reg;
        tempo_next = tempo_reg;
        fdb_next   = fdb_reg;
        res_valid  = 1'b0;
        res_kind   = EV_ERROR;
        res_code   = ERR_NONE;
        res_ch     = '0;
        res_key    = '0;
        res_vel    = '0;
        res_tempo  = '0;
        finish     = 1'b0;

        if (in_new_reg)
        begin
            tick_next  = '0;
            vlq_next   = '0;
            mkind_next = '0;
            mrem_next  = '0;
            mcnt_next  = '0;
            tempo_next = '0;
            track_next = in_id_reg;
            phase_next = PH_DELTA;
        end

        case (phase_next)
            PH_DELTA:
            begin
                vlq_next = {vlq_next[24:0], b[6:0]};
                if (!b[7])
                begin
                    tick_next  = tick_next + vlq_next;
                    vlq_next   = '0;
                    phase_next = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (b[7])
                begin
                    if (b == META_PREFIX)
                    begin
                        rs_next    = '0;
                        phase_next = PH_META_TYPE;
                    end
                    else if (b >= STATUS_SYS)
                    begin
                        res_valid = 1'b1;
                        res_code  = ERR_BAD_STATUS;
                    end
                    else
                    begin
                        rs_next = b;
                        if (!ch_type_handled(b[7:4]))
                        begin
                            res_valid = 1'b1;
                            res_code  = ERR_CH_TYPE;
                        end
                        else
                        begin
                            phase_next = PH_CH_D1;
                        end
                    end
                end
                else if (!rs_next[7] || rs_next > STATUS_CH_MAX)
                begin
                    res_valid = 1'b1;
                    res_code  = ERR_BAD_STATUS;
                end
                else if (!ch_type_handled(rs_next[7:4]))
                begin
                    res_valid = 1'b1;
                    res_code  = ERR_CH_TYPE;
                end
                else
                begin
                    fdb_next   = b;
                    phase_next = (rs_next[7:4] == CH_PROGRAM) ? PH_DELTA : PH_CH_D2;
                end
            end
            PH_CH_D1:
            begin
                fdb_next   = b;
                phase_next = (rs_next[7:4] == CH_PROGRAM) ? PH_DELTA : PH_CH_D2;
            end
            PH_CH_D2:
            begin
                phase_next = PH_DELTA;
                if (rs_next[7:4] == CH_NOTE_OFF || rs_next[7:4] == CH_NOTE_ON)
                begin
                    res_valid = 1'b1;
                    res_kind  = (rs_next[7:4] == CH_NOTE_ON) ? EV_NOTE_ON : EV_NOTE_OFF;
                    res_ch    = rs_next[3:0];
                    res_key   = fdb_next;
                    res_vel   = b;
                end
            end
            PH_META_TYPE:
            begin
                mkind_next = b;
                vlq_next   = '0;
                phase_next = PH_META_LEN;
            end
            PH_META_LEN:
            begin
                vlq_next = {vlq_next[24:0], b[6:0]};
                if (!b[7])
                begin
                    mrem_next  = vlq_next;
                    vlq_next   = '0;
                    mcnt_next  = '0;
                    tempo_next = '0;
                    if (mrem_next == '0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_META_DATA;
                    end
                end
            end
            PH_META_DATA:
            begin
                if (mcnt_next >= META_CNT_W'(MAX_META_LEN))
                begin
                    res_valid = 1'b1;
                    res_code  = ERR_META_LONG;
                end
                else
                begin
                    if (mcnt_next < META_CNT_W'(3))
                    begin
                        tempo_next = {tempo_next[15:0], b};
                    end
                    mcnt_next = mcnt_next + 1'b1;
                    mrem_next = mrem_next - 32'd1;
                    finish    = (mrem_next == '0);
                end
            end
            default:
            begin
            end
        endcase

        if (finish)
        begin
            phase_next = PH_DELTA;
            case (mkind_next)
                META_SET_TEMPO:
                begin
                    res_valid = 1'b1;
                    if (mcnt_next != META_CNT_W'(3))
                    begin
                        res_code = ERR_TEMPO_LEN;
                    end
                    else
                    begin
                        res_kind  = EV_TEMPO;
                        res_tempo = tempo_next;
                    end
                end
                META_TRACK_NAME:
                begin
                    res_valid = 1'b1;
                    res_kind  = EV_TRACK_NAME;
                end
                META_END_TRACK:
                begin
                    res_valid  = 1'b1;
                    res_kind   = EV_END_TRACK;
                    phase_next = PH_HALT;
                end
                META_TIME_SIG, META_MARKER:
                begin
                end
                default:
                begin
                    res_valid = 1'b1;
                    res_code  = ERR_META_TYPE;
                end
            endcase
        end

        // every error halts until the next new track
        if (res_valid && res_kind == EV_ERROR)
        begin
            phase_next = PH_HALT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HALT;
            vlq_reg   <= '0;
            tick_reg  <= '0;
            rs_reg    <= '0;
            track_reg <= '0;
            mkind_reg <= '0;
            mrem_reg  <= '0;
            mcnt_reg  <= '0;
            tempo_reg <= '0;
            fdb_reg   <= '0;
        end
        else if (proc)
        begin
            phase_reg <= phase_next;
            vlq_reg   <= vlq_next;
            tick_reg  <= tick_next;
            rs_reg    <= rs_next;
            track_reg <= track_next;
            mkind_reg <= mkind_next;
            mrem_reg  <= mrem_next;
            mcnt_reg  <= mcnt_next;
            tempo_reg <= tempo_next;
            fdb_reg   <= fdb_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= proc && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && res_valid)
        begin
            out_kind_reg  <= res_kind;
            out_code_reg  <= res_code;
            out_tick_reg  <= tick_next;
            out_track_reg <= track_next;
            out_ch_reg    <= res_ch;
            out_key_reg   <= res_key;
            out_vel_reg   <= res_vel;
            out_tempo_reg <= res_tempo;
        end
    end

    assign events.valid        = out_valid_reg;
    assign events.event_kind   = out_kind_reg;
    assign events.error_code   = out_code_reg;
    assign events.tick_time    = out_tick_reg;
    assign events.track_number = out_track_reg;
    assign events.channel      = out_ch_reg;
    assign events.note_key     = out_key_reg;
    assign events.velocity     = out_vel_reg;
    assign events.tempo_us     = out_tempo_reg;

`ifndef SYNTHESIS
    a_err_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == EV_ERROR |-> out_code_reg != ERR_NONE)
        else $error("error event without error code");

    a_ok_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg != EV_ERROR |-> out_code_reg == ERR_NONE)
        else $error("non-error event carries error code");

    a_halt_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        proc && res_valid && (res_kind == EV_ERROR || res_kind == EV_END_TRACK)
        |=> phase_reg == PH_HALT)
        else $error("parser not halted after error or end of track");

    a_meta_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        mcnt_reg <= META_CNT_W'(MAX_META_LEN))
        else $error("meta byte count past limit");
`endif

endmodule
